>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live through reset
`define ASR_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Shared widths, constants and the beat record of the arcsine pipeline.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int SERIES_TERMS_DEF = 6;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int IN_W  = 18;  // argument and angle width
  localparam int Q_W   = 32;  // internal Q0.32 width
  localparam int SUM_W = 34;  // series accumulator
  localparam int REM_W = 11;  // holds twice the largest term divisor

  localparam logic [IN_W-1:0] MAG_MAX   = 18'h1FFFF;
  localparam logic [IN_W-1:0] ANGLE_MIN = 18'h20000;
  localparam logic [36:0]     HALF_PI_Q32 = 37'h1921FB544;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             clamp;
    logic [Q_W-1:0]   term;
    logic [Q_W-1:0]   x2;
    logic [SUM_W-1:0] sum;
  } asr_beat_t;

  // pi/2 rounded half up to frac_bits fraction bits, limited to MAG_MAX
  function automatic logic [IN_W-1:0] asr_half_pi(input int unsigned frac_bits);
    logic [36:0] rnd;
    int unsigned sh;
    sh  = 32 - frac_bits;
    rnd = (HALF_PI_Q32 + (37'd1 << (sh - 1))) >> sh;
    return (rnd > 37'(MAG_MAX)) ? MAG_MAX : rnd[IN_W-1:0];
  endfunction

endpackage

>>> hdl/asr_front.sv
// ----------------------------------------------------------------------------
// asr_front
// Input register, magnitude and clamp detect, then x squared in Q0.32.
// ----------------------------------------------------------------------------
module asr_front import asr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [IN_W-1:0] in_x_value,
  output asr_beat_t              out_beat
);

  localparam int          SHL = Q_W - FRAC_BITS;
  localparam logic [Q_W-1:0] ONE = Q_W'(64'd1 << FRAC_BITS);

  asr_beat_t         p0_r, p0_nxt;
  asr_beat_t         p1_r, p1_nxt;
  logic [IN_W-1:0]   xu;
  logic [IN_W-1:0]   mag;
  logic [2*Q_W-1:0]  sq;

  always_comb begin
    xu  = in_x_value;
    mag = xu[IN_W-1] ? (~xu + 1'b1) : xu;
    p0_nxt       = '0;
    p0_nxt.vld   = in_valid;
    p0_nxt.neg   = xu[IN_W-1];
    p0_nxt.clamp = (Q_W'(mag) >= ONE);
    p0_nxt.term  = Q_W'(mag) << SHL;
  end

  // series starts with term = a, sum = 0 (total is always sum + term)
  always_comb begin
    sq        = (2*Q_W)'(p0_r.term) * (2*Q_W)'(p0_r.term);
    p1_nxt    = p0_r;
    p1_nxt.x2 = sq[2*Q_W-1:Q_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r.vld <= 1'b0;
      p1_r.vld <= 1'b0;
    end else if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
    end
  end

  assign out_beat = p1_r;

endmodule

>>> hdl/asr_term.sv
// ----------------------------------------------------------------------------
// asr_term
// One series term: term*x^2, then term*(2n-1)^2/(2n(2n+1)) by a reciprocal
// multiply with a one-step correction. Three register stages.
// ----------------------------------------------------------------------------
module asr_term import asr_pkg::*; #(
  parameter int N = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  asr_beat_t in_beat,
  output asr_beat_t out_beat
);

  localparam int unsigned ODD = 2 * N - 1;
  localparam int unsigned O2  = ODD * ODD;
  localparam int unsigned DEN = 2 * N * (2 * N + 1);
  localparam logic [63:0] MC_FULL = (64'(O2) << 32) / DEN;
  localparam logic [Q_W-1:0]   MC     = MC_FULL[Q_W-1:0];
  localparam logic [REM_W-1:0] O2_LO  = REM_W'(O2);
  localparam logic [REM_W-1:0] DEN_LO = REM_W'(DEN);

  asr_beat_t        a_r, a_nxt;
  asr_beat_t        b_r, b_nxt;
  asr_beat_t        c_r, c_nxt;
  logic [Q_W-1:0]   q0_r, q0_nxt;
  logic [2*Q_W-1:0] prod_a;
  logic [2*Q_W-1:0] prod_b;
  logic [REM_W-1:0] p_lo;
  logic [REM_W-1:0] qd_lo;
  logic [REM_W-1:0] rem;
  logic             fix;

  // stage A: scale by x^2, fold the previous term into the sum
  always_comb begin
    prod_a     = (2*Q_W)'(in_beat.term) * (2*Q_W)'(in_beat.x2);
    a_nxt      = in_beat;
    a_nxt.term = prod_a[2*Q_W-1:Q_W];
    a_nxt.sum  = in_beat.sum + SUM_W'(in_beat.term);
  end

  // stage B: quotient estimate, low by at most one
  always_comb begin
    prod_b = (2*Q_W)'(a_r.term) * (2*Q_W)'(MC);
    b_nxt  = a_r;
    q0_nxt = prod_b[2*Q_W-1:Q_W];
  end

  // stage C: remainder lies in [0, 2*DEN), so low bits suffice
  always_comb begin
    p_lo       = b_r.term[REM_W-1:0] * O2_LO;
    qd_lo      = q0_r[REM_W-1:0] * DEN_LO;
    rem        = p_lo - qd_lo;
    fix        = (rem >= DEN_LO);
    c_nxt      = b_r;
    c_nxt.term = q0_r + Q_W'(fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
      c_r.vld <= 1'b0;
    end else if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      q0_r <= q0_nxt;
      c_r  <= c_nxt;
    end
  end

  assign out_beat = c_r;

endmodule

>>> hdl/asr_back.sv
// ----------------------------------------------------------------------------
// asr_back
// Final sum, round to the output format, saturate, clamp select and sign.
// ----------------------------------------------------------------------------
module asr_back import asr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  asr_beat_t              in_beat,
  output logic                   out_valid,
  output logic signed [IN_W-1:0] out_angle,
  output logic                   out_clamped
);

  localparam int SHR = Q_W - FRAC_BITS;
  localparam int RW  = SUM_W + 1;
  localparam logic [RW-1:0]   RND_ADD = RW'(1) << (SHR - 1);
  localparam logic [IN_W-1:0] HP_MAG  = asr_half_pi(FRAC_BITS);

  asr_beat_t       f1_r, f1_nxt;
  logic            vld_r;
  logic [IN_W-1:0] angle_r, angle_nxt;
  logic            clamped_r;
  logic [RW-1:0]   rnd_sum;
  logic [RW-1:0]   rnd_q;
  logic [IN_W-1:0] mag_sat;
  logic [IN_W-1:0] mag_sel;

  always_comb begin
    f1_nxt     = in_beat;
    f1_nxt.sum = in_beat.sum + SUM_W'(in_beat.term);
  end

  always_comb begin
    rnd_sum   = RW'(f1_r.sum) + RND_ADD;
    rnd_q     = rnd_sum >> SHR;
    mag_sat   = (rnd_q > RW'(MAG_MAX)) ? MAG_MAX : rnd_q[IN_W-1:0];
    mag_sel   = f1_r.clamp ? HP_MAG : mag_sat;
    angle_nxt = f1_r.neg ? (~mag_sel + 1'b1) : mag_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.vld <= 1'b0;
      vld_r    <= 1'b0;
    end else if (en) begin
      f1_r      <= f1_nxt;
      vld_r     <= f1_r.vld;
      angle_r   <= angle_nxt;
      clamped_r <= f1_r.clamp;
    end
  end

  assign out_valid   = vld_r;
  assign out_angle   = angle_r;
  assign out_clamped = clamped_r;

endmodule

>>> hdl/arcsin_series.sv
// Throughput: one beat per cycle unless a held output stalls the pipe; x^2 has one stage
//   with a 32x32 multiplier, each series term takes three stages (two with one 32x32
//   multiplier each), no stage is reused.
// A held output freezes the whole pipe; in_ready follows out_ready combinationally.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep their value.
// ----------------------------------------------------------------------------
// arcsin_series
// Pipelined arcsine of a Q1.FRAC_BITS value by a truncated Maclaurin series,
// with +-pi/2 clamp for |x| >= 1.
// ----------------------------------------------------------------------------
module arcsin_series import asr_pkg::*; #(
  parameter int SERIES_TERMS = SERIES_TERMS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] in_x_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [IN_W-1:0] out_angle,
  output logic                   out_clamped
);

  asr_beat_t stg [SERIES_TERMS];
  logic      en;

  // pipe advances unless a finished beat is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  asr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_x_value (in_x_value),
    .out_beat   (stg[0])
  );

  for (genvar i = 1; i < SERIES_TERMS; i++) begin : g_term
    asr_term #(
      .N (i)
    ) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_beat  (stg[i-1]),
      .out_beat (stg[i])
    );
  end

  asr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_beat     (stg[SERIES_TERMS-1]),
    .out_valid   (out_valid),
    .out_angle   (out_angle),
    .out_clamped (out_clamped)
  );

endmodule

>>> hdl/asr_checker.sv
// ----------------------------------------------------------------------------
// asr_checker
// Port-level checks on the arcsine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asr_checker import asr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [IN_W-1:0] out_angle,
  input logic            out_clamped
);

  localparam logic [IN_W-1:0] HP     = asr_half_pi(FRAC_BITS);
  localparam logic [IN_W-1:0] HP_NEG = ~HP + 1'b1;

  `ASR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_angle) && $stable(out_clamped), "result beat changed while stalled")
  `ASR_ASSERT_NOW(a_clamp_val, out_valid && out_clamped, out_angle == HP || out_angle == HP_NEG, "clamped beat is not +-pi/2")
  `ASR_ASSERT_NOW(a_no_min, out_valid, out_angle != ANGLE_MIN, "angle reached the most negative code")
  `ASR_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input held while output stage is empty")
  `ASR_ASSERT_RST(a_rst_clear, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind arcsin_series asr_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_asr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_angle   (out_angle),
  .out_clamped (out_clamped)
);
